@@ hdl/hbwd_pkg.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog package
// Table geometry, codes, and the command/status records shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hbwd_pkg;

    localparam int MAX_CLUSTER_SLOTS = 4;
    localparam int MAX_RACK_SLOTS    = 16;
    localparam int MAX_EVENTS        = 64;
    localparam int NUM_CH            = MAX_CLUSTER_SLOTS * MAX_RACK_SLOTS;

    localparam int CL_W   = 2;
    localparam int RK_W   = 4;
    localparam int TIME_W = 32;
    localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int CLC_W  = $clog2(MAX_CLUSTER_SLOTS + 1);
    localparam int RKC_W  = $clog2(MAX_RACK_SLOTS + 1);
    localparam int EVC_W  = $clog2(MAX_EVENTS + 1);

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_CLUSTERS = 2'd1;
    localparam logic [1:0] REG_RACKS    = 2'd2;

    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd1000;
    localparam logic [2:0]        CLUSTERS_RST = 3'd4;
    localparam logic [4:0]        RACKS_RST    = 5'd16;

    localparam logic EV_FAULT   = 1'b0;
    localparam logic EV_RECOVER = 1'b1;

    typedef enum logic [1:0] {
        ACT_HEARTBEAT = 2'd0,
        ACT_INIT      = 2'd1,
        ACT_CHECK     = 2'd2
    } hbwd_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HB_RD,
        ST_HB_WR,
        ST_INIT,
        ST_SCAN,
        ST_FLUSH
    } hbwd_state_t;

    typedef struct packed {
        logic            cap;
        logic            hb_rd;
        logic            hb_wr;
        logic            init_wr;
        logic            scan_rd;
        logic            ev_clr;
        logic            flush;
        logic [CH_W-1:0] addr;
        logic [CL_W-1:0] cl;
        logic [RK_W-1:0] rk;
    } hbwd_cmd_t;

    typedef struct packed {
        logic             stall;
        logic             s1_valid;
        logic             pend_valid;
        logic [CLC_W-1:0] nc;
        logic [RKC_W-1:0] nr;
    } hbwd_stat_t;

    typedef struct packed {
        logic              kind;
        logic [CL_W-1:0]   cl;
        logic [RK_W-1:0]   rk;
        logic [TIME_W-1:0] age;
    } hbwd_event_t;

    function automatic logic [CH_W-1:0] ch_addr(input logic [CLC_W-1:0] c,
                                               input logic [RKC_W-1:0] r);
        logic [31:0] full;
        full = 32'(c) * 32'(MAX_RACK_SLOTS) + 32'(r);
        return full[CH_W-1:0];
    endfunction

endpackage

@@ hdl/hbwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog controller
// Sequences heartbeat updates, init sweeps and check scans over the table.
// ----------------------------------------------------------------------------
module hbwd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           action,
    input  hbwd_pkg::hbwd_stat_t stat,
    output hbwd_pkg::hbwd_cmd_t  cmd
);

    hbwd_pkg::hbwd_state_t state_reg, state_next;
    logic [hbwd_pkg::CLC_W-1:0] cl_cnt_reg, cl_cnt_next;
    logic [hbwd_pkg::RKC_W-1:0] rk_cnt_reg, rk_cnt_next;
    logic issue_left;
    logic advance;

    assign issue_left = (cl_cnt_reg < stat.nc) && (stat.nr != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hbwd_pkg::ST_IDLE;
            cl_cnt_reg <= '0;
            rk_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cl_cnt_reg <= cl_cnt_next;
            rk_cnt_reg <= rk_cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cl_cnt_next = cl_cnt_reg;
        rk_cnt_next = rk_cnt_reg;
        advance     = 1'b0;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.addr    = hbwd_pkg::ch_addr(cl_cnt_reg, rk_cnt_reg);
        cmd.cl      = hbwd_pkg::CL_W'(cl_cnt_reg);
        cmd.rk      = hbwd_pkg::RK_W'(rk_cnt_reg);

        case (state_reg)
            hbwd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap     = 1'b1;
                    cl_cnt_next = '0;
                    rk_cnt_next = '0;
                    case (hbwd_pkg::hbwd_action_t'(action))
                        hbwd_pkg::ACT_HEARTBEAT: state_next = hbwd_pkg::ST_HB_RD;
                        hbwd_pkg::ACT_INIT:      state_next = hbwd_pkg::ST_INIT;
                        hbwd_pkg::ACT_CHECK:
                        begin
                            cmd.ev_clr = 1'b1;
                            state_next = hbwd_pkg::ST_SCAN;
                        end
                        default:                 state_next = hbwd_pkg::ST_IDLE;
                    endcase
                end
            end
            hbwd_pkg::ST_HB_RD:
            begin
                cmd.hb_rd  = 1'b1;
                state_next = hbwd_pkg::ST_HB_WR;
            end
            hbwd_pkg::ST_HB_WR:
            begin
                cmd.hb_wr  = 1'b1;
                state_next = hbwd_pkg::ST_IDLE;
            end
            hbwd_pkg::ST_INIT:
            begin
                if (issue_left)
                begin
                    cmd.init_wr = 1'b1;
                    advance     = 1'b1;
                end
                else
                begin
                    state_next = hbwd_pkg::ST_IDLE;
                end
            end
            hbwd_pkg::ST_SCAN:
            begin
                if (issue_left && !stat.stall)
                begin
                    cmd.scan_rd = 1'b1;
                    advance     = 1'b1;
                end
                if (!issue_left && (!stat.s1_valid || !stat.stall))
                begin
                    state_next = hbwd_pkg::ST_FLUSH;
                end
            end
            hbwd_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!stat.pend_valid)
                begin
                    state_next = hbwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbwd_pkg::ST_IDLE;
            end
        endcase

        // advance cluster-major, rack-minor
        if (advance)
        begin
            if ((rk_cnt_reg + hbwd_pkg::RKC_W'(1)) < stat.nr)
            begin
                rk_cnt_next = rk_cnt_reg + hbwd_pkg::RKC_W'(1);
            end
            else
            begin
                rk_cnt_next = '0;
                cl_cnt_next = cl_cnt_reg + hbwd_pkg::CLC_W'(1);
            end
        end
    end

endmodule

@@ hdl/hbwd_datapath.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog datapath
// Channel table memories, config registers, age compare stage and the
// one-deep event lookahead feeding the output register.
// ----------------------------------------------------------------------------
module hbwd_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_addr,
    input  logic [hbwd_pkg::TIME_W-1:0]        cfg_wdata,
    input  logic [hbwd_pkg::CL_W-1:0]          in_cluster,
    input  logic [hbwd_pkg::RK_W-1:0]          in_rack,
    input  logic [hbwd_pkg::TIME_W-1:0]        in_time,
    input  hbwd_pkg::hbwd_cmd_t                cmd,
    output hbwd_pkg::hbwd_stat_t               stat,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    output hbwd_pkg::hbwd_event_t              m_event
);

    localparam int FL_LINK = 0;
    localparam int FL_REP  = 1;

    logic [hbwd_pkg::TIME_W-1:0] timeout_reg;
    logic [2:0]                  ccnt_reg;
    logic [4:0]                  rcnt_reg;

    logic [hbwd_pkg::CL_W-1:0]   it_cl_reg;
    logic [hbwd_pkg::RK_W-1:0]   it_rk_reg;
    logic [hbwd_pkg::TIME_W-1:0] it_time_reg;

    logic [hbwd_pkg::TIME_W-1:0] ls_mem [hbwd_pkg::NUM_CH];
    logic [1:0]                  fl_mem [hbwd_pkg::NUM_CH];
    logic [hbwd_pkg::TIME_W-1:0] ls_rd_reg;
    logic [1:0]                  fl_rd_reg;
    logic [hbwd_pkg::NUM_CH-1:0] vld_reg, vld_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic [hbwd_pkg::CH_W-1:0]   s1_addr_reg;
    logic [hbwd_pkg::CL_W-1:0]   s1_cl_reg;
    logic [hbwd_pkg::RK_W-1:0]   s1_rk_reg;
    logic                        s1_vld_reg;

    logic [hbwd_pkg::EVC_W-1:0]  ev_cnt_reg, ev_cnt_next;

    logic                        pend_valid_reg, pend_valid_next;
    hbwd_pkg::hbwd_event_t       pend_ev_reg, pend_ev_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_last_reg, out_last_next;
    hbwd_pkg::hbwd_event_t       out_ev_reg, out_ev_next;

    logic                        hb_ok;
    logic [hbwd_pkg::CH_W-1:0]   hb_addr;
    logic [hbwd_pkg::CH_W-1:0]   addr_sel;
    logic [hbwd_pkg::TIME_W-1:0] ls_eff;
    logic [hbwd_pkg::TIME_W-1:0] age;
    logic                        stale;
    logic                        fault;
    logic                        recov;
    logic                        ev;
    logic                        ev_under;
    logic                        out_free;
    logic                        stall;
    logic                        s1_fire;
    logic                        push;
    logic                        hb_write;
    logic                        ls_we;
    logic                        fl_we;
    logic [hbwd_pkg::CH_W-1:0]   fl_wa;
    logic [1:0]                  fl_wd;
    logic                        fl_re;
    hbwd_pkg::hbwd_event_t       new_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= hbwd_pkg::TIMEOUT_RST;
            ccnt_reg    <= hbwd_pkg::CLUSTERS_RST;
            rcnt_reg    <= hbwd_pkg::RACKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hbwd_pkg::REG_TIMEOUT:  timeout_reg <= cfg_wdata;
                hbwd_pkg::REG_CLUSTERS: ccnt_reg    <= cfg_wdata[2:0];
                hbwd_pkg::REG_RACKS:    rcnt_reg    <= cfg_wdata[4:0];
                default:                ;
            endcase
        end
    end

    assign stat.nc = (32'(ccnt_reg) > hbwd_pkg::MAX_CLUSTER_SLOTS)
                   ? hbwd_pkg::CLC_W'(hbwd_pkg::MAX_CLUSTER_SLOTS)
                   : hbwd_pkg::CLC_W'(ccnt_reg);
    assign stat.nr = (32'(rcnt_reg) > hbwd_pkg::MAX_RACK_SLOTS)
                   ? hbwd_pkg::RKC_W'(hbwd_pkg::MAX_RACK_SLOTS)
                   : hbwd_pkg::RKC_W'(rcnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            it_cl_reg   <= in_cluster;
            it_rk_reg   <= in_rack;
            it_time_reg <= in_time;
        end
    end

    assign hb_ok    = (32'(it_cl_reg) < hbwd_pkg::MAX_CLUSTER_SLOTS)
                   && (32'(it_rk_reg) < hbwd_pkg::MAX_RACK_SLOTS);
    assign hb_addr  = hbwd_pkg::ch_addr(hbwd_pkg::CLC_W'(it_cl_reg),
                                        hbwd_pkg::RKC_W'(it_rk_reg));
    assign addr_sel = (cmd.hb_rd || cmd.hb_wr) ? hb_addr : cmd.addr;
    assign hb_write = cmd.hb_wr && hb_ok;

    // age compare on the registered read word; an unwritten entry reads zero
    assign ls_eff   = s1_vld_reg ? ls_rd_reg : '0;
    assign age      = it_time_reg - ls_eff;
    assign stale    = age > timeout_reg;
    assign fault    = s1_vld_reg && stale && fl_rd_reg[FL_REP];
    assign recov    = s1_vld_reg && !stale && fl_rd_reg[FL_LINK] && !fl_rd_reg[FL_REP];
    assign ev       = fault || recov;
    assign ev_under = ev_cnt_reg < hbwd_pkg::EVC_W'(hbwd_pkg::MAX_EVENTS);
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = s1_valid_reg && ev && ev_under && pend_valid_reg && !out_free;
    assign s1_fire  = s1_valid_reg && !stall;
    assign push     = s1_fire && ev && ev_under;

    assign new_ev.kind = fault ? hbwd_pkg::EV_FAULT : hbwd_pkg::EV_RECOVER;
    assign new_ev.cl   = s1_cl_reg;
    assign new_ev.rk   = s1_rk_reg;
    assign new_ev.age  = fault ? age : '0;

    assign ls_we = hb_write || cmd.init_wr;
    assign fl_re = cmd.scan_rd || cmd.hb_rd;

    always_comb
    begin
        fl_we = 1'b0;
        fl_wa = addr_sel;
        fl_wd = 2'b00;
        if (s1_fire && ev)
        begin
            fl_we = 1'b1;
            fl_wa = s1_addr_reg;
            fl_wd = fault ? 2'b00 : 2'b11;
        end
        else if (hb_write)
        begin
            fl_we          = 1'b1;
            fl_wd[FL_LINK] = 1'b1;
            fl_wd[FL_REP]  = vld_reg[hb_addr] && fl_rd_reg[FL_REP];
        end
        else if (cmd.init_wr && !vld_reg[addr_sel])
        begin
            fl_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[addr_sel] <= it_time_reg;
        end
        if (cmd.scan_rd)
        begin
            ls_rd_reg <= ls_mem[addr_sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            fl_mem[fl_wa] <= fl_wd;
        end
        if (fl_re)
        begin
            fl_rd_reg <= fl_mem[addr_sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            s1_addr_reg <= cmd.addr;
            s1_cl_reg   <= cmd.cl;
            s1_rk_reg   <= cmd.rk;
            s1_vld_reg  <= vld_reg[cmd.addr];
        end
        pend_ev_reg <= pend_ev_next;
        out_ev_reg  <= out_ev_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ls_we)
        begin
            vld_next[addr_sel] = 1'b1;
        end

        s1_valid_next = s1_valid_reg;
        if (cmd.scan_rd)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        ev_cnt_next = ev_cnt_reg;
        if (cmd.ev_clr)
        begin
            ev_cnt_next = '0;
        end
        else if (push)
        begin
            ev_cnt_next = ev_cnt_reg + hbwd_pkg::EVC_W'(1);
        end

        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_ev_next    = pend_ev_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_ev_next    = new_ev;
        end
        else if (cmd.flush && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_ev_next     = pend_ev_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            ev_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            vld_reg        <= vld_next;
            s1_valid_reg   <= s1_valid_next;
            ev_cnt_reg     <= ev_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign stat.stall      = stall;
    assign stat.s1_valid   = s1_valid_reg;
    assign stat.pend_valid = pend_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_event  = out_ev_reg;

    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> (pend_valid_reg && out_valid_reg))
        else $error("stall without a pending and a held word");

    a_flush_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush && pend_valid_reg && out_free && !push) |=>
        (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("flushed word not marked last");

    a_event_on_written_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && ev) |-> s1_vld_reg)
        else $error("event raised on an unwritten channel");

    a_event_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (ev_cnt_reg < hbwd_pkg::EVC_W'(hbwd_pkg::MAX_EVENTS)))
        else $error("event count past limit");

endmodule

@@ hdl/multi_channel_heartbeat_watchdog.sv @@
// ----------------------------------------------------------------------------
// Multi-channel heartbeat watchdog
// Heartbeat: each word is accepted, then its flags are read, then the table is
// written. Init: every channel in use is written in turn. Check tick: one channel
// read per cycle over the channels in use, unless an event push is held by output
// back-pressure. An event word is held one word deep for tlast and leaves when the
// next event of the tick is found or the scan ends. rst_n (async, low) clears valid
// bits, so every channel reads as never seen, and loads register defaults.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cluster[1:0], rack[5:2], time_ms[37:6], zero[39:38]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // event_cluster[1:0], event_rack[5:2], age_ms[37:6], zero
    output logic        m_tuser,   // event_kind[0]
    output logic        m_tlast
);

    hbwd_pkg::hbwd_cmd_t   cmd;
    hbwd_pkg::hbwd_stat_t  stat;
    hbwd_pkg::hbwd_event_t m_event;

    hbwd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    hbwd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_cluster (s_tdata[1:0]),
        .in_rack    (s_tdata[5:2]),
        .in_time    (s_tdata[37:6]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tlast    (m_tlast),
        .m_event    (m_event)
    );

    assign m_tdata = {2'b00, m_event.age, m_event.rk, m_event.cl};
    assign m_tuser = m_event.kind;

endmodule

@@ tb/multi_channel_heartbeat_watchdog_checker.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog event checker
// Watches the register port and both streams of the watchdog. Keeps its own
// copy of the channel table and the registers, works out the fault and
// recovery words each accepted check tick must produce, and compares every
// event word that leaves the block against the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_channel_heartbeat_watchdog_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // cluster[1:0], rack[5:2], time_ms[37:6], zero[39:38]
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // event_cluster[1:0], event_rack[5:2], age_ms[37:6], zero
    input  logic        m_tuser,   // event_kind[0]
    input  logic        m_tlast,
    output logic [31:0] mismatch_count,
    output logic [31:0] expected_left,
    output logic [31:0] fault_count,
    output logic [31:0] recover_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        hbwd_pkg::hbwd_event_t ev;
        logic                  last;
    } due_event_t;

    logic [hbwd_pkg::TIME_W-1:0] seen_ms  [hbwd_pkg::NUM_CH];
    logic                        online   [hbwd_pkg::NUM_CH];
    logic                        reported [hbwd_pkg::NUM_CH];
    logic [hbwd_pkg::TIME_W-1:0] stale_after_ms;
    logic [2:0]                  clusters_cfg;
    logic [4:0]                  racks_cfg;

    due_event_t due_events [$];
    int         errors;
    int         faults;
    int         recovers;

    function automatic int used_clusters();
        return (clusters_cfg > hbwd_pkg::MAX_CLUSTER_SLOTS)
             ? hbwd_pkg::MAX_CLUSTER_SLOTS : int'(clusters_cfg);
    endfunction

    function automatic int used_racks();
        return (racks_cfg > hbwd_pkg::MAX_RACK_SLOTS)
             ? hbwd_pkg::MAX_RACK_SLOTS : int'(racks_cfg);
    endfunction

    task automatic update_table(input logic [1:0]                  act,
                                input logic [hbwd_pkg::CL_W-1:0]   cl,
                                input logic [hbwd_pkg::RK_W-1:0]   rk,
                                input logic [hbwd_pkg::TIME_W-1:0] now_ms);
        int                          nc;
        int                          nr;
        int                          ch;
        int                          emitted;
        logic [hbwd_pkg::TIME_W-1:0] age;
        logic                        stale;
        due_event_t                  e;
        nc = used_clusters();
        nr = used_racks();
        emitted = 0;
        case (act)
            hbwd_pkg::ACT_HEARTBEAT:
            begin
                ch = int'(cl) * hbwd_pkg::MAX_RACK_SLOTS + int'(rk);
                seen_ms[ch] = now_ms;
                online[ch]  = 1'b1;
            end
            hbwd_pkg::ACT_INIT:
            begin
                for (int c = 0; c < nc; c++)
                    for (int r = 0; r < nr; r++)
                        seen_ms[c * hbwd_pkg::MAX_RACK_SLOTS + r] = now_ms;
            end
            hbwd_pkg::ACT_CHECK:
            begin
                for (int c = 0; c < nc; c++)
                begin
                    for (int r = 0; r < nr; r++)
                    begin
                        ch     = c * hbwd_pkg::MAX_RACK_SLOTS + r;
                        age    = now_ms - seen_ms[ch];
                        stale  = age > stale_after_ms;
                        e.ev.cl = c[hbwd_pkg::CL_W-1:0];
                        e.ev.rk = r[hbwd_pkg::RK_W-1:0];
                        e.last  = 1'b0;
                        if (stale && reported[ch])
                        begin
                            online[ch]   = 1'b0;
                            reported[ch] = 1'b0;
                            e.ev.kind    = hbwd_pkg::EV_FAULT;
                            e.ev.age     = age;
                            if (emitted < hbwd_pkg::MAX_EVENTS)
                            begin
                                due_events.push_back(e);
                                emitted++;
                            end
                        end
                        else if (!stale && online[ch] && !reported[ch])
                        begin
                            reported[ch] = 1'b1;
                            e.ev.kind    = hbwd_pkg::EV_RECOVER;
                            e.ev.age     = '0;
                            if (emitted < hbwd_pkg::MAX_EVENTS)
                            begin
                                due_events.push_back(e);
                                emitted++;
                            end
                        end
                    end
                end
                // mark the final word of this tick
                if (emitted > 0)
                begin
                    e = due_events.pop_back();
                    e.last = 1'b1;
                    due_events.push_back(e);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_event();
        due_event_t  want;
        logic [39:0] want_data;
        if (due_events.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: unexpected event word: kind %0d cl %0d rk %0d age %0d last %0d",
                         $time, m_tuser, m_tdata[1:0], m_tdata[5:2], m_tdata[37:6],
                         m_tlast);
        end
        else
        begin
            want = due_events.pop_front();
            want_data = {2'b00, want.ev.age, want.ev.rk, want.ev.cl};
            if (want.ev.kind == hbwd_pkg::EV_FAULT)
                faults++;
            else
                recovers++;
            if (m_tuser !== want.ev.kind || m_tdata !== want_data || m_tlast !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("%0t: event mismatch: expected kind %0d cl %0d rk %0d age %0d",
                             $time, want.ev.kind, want.ev.cl, want.ev.rk, want.ev.age);
                    $display("%0t:   expected last %0d", $time, want.last);
                    $display("%0t:   actual   kind %0d cl %0d rk %0d age %0d",
                             $time, m_tuser, m_tdata[1:0], m_tdata[5:2], m_tdata[37:6]);
                    $display("%0t:   actual   last %0d pad %0d",
                             $time, m_tlast, m_tdata[39:38]);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hbwd_pkg::NUM_CH; i++)
            begin
                seen_ms[i]  = '0;
                online[i]   = 1'b0;
                reported[i] = 1'b0;
            end
            stale_after_ms = hbwd_pkg::TIMEOUT_RST;
            clusters_cfg   = hbwd_pkg::CLUSTERS_RST;
            racks_cfg      = hbwd_pkg::RACKS_RST;
            due_events.delete();
            errors   = 0;
            faults   = 0;
            recovers = 0;
        end
        else
        begin
            // outgoing words always belong to earlier ticks
            if (m_tvalid && m_tready)
                check_event();
            if (cfg_we)
            begin
                case (cfg_addr)
                    hbwd_pkg::REG_TIMEOUT:  stale_after_ms = cfg_wdata;
                    hbwd_pkg::REG_CLUSTERS: clusters_cfg   = cfg_wdata[2:0];
                    hbwd_pkg::REG_RACKS:    racks_cfg      = cfg_wdata[4:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                update_table(s_tuser, s_tdata[1:0], s_tdata[5:2], s_tdata[37:6]);
        end
        mismatch_count <= errors;
        expected_left  <= due_events.size();
        fault_count    <= faults;
        recover_count  <= recovers;
    end

endmodule

@@ tb/multi_channel_heartbeat_watchdog_tb.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog testbench
// Drives heartbeat, init and check-tick words into the watchdog: a directed
// opening at reset settings, then random traffic under six register settings
// with varying source idling and sink back-pressure. The checker predicts and
// compares the event stream; this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_channel_heartbeat_watchdog_tb;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT   = 5000;
    localparam int         QUIET_CYCLES = 120;
    localparam int         NUM_SETTINGS = 6;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic [31:0] mismatch_count;
    logic [31:0] expected_left;
    logic [31:0] fault_count;
    logic [31:0] recover_count;

    int          src_idle_pct;
    int          sink_stall_pct;
    int          idle_cycles;
    int          n_heartbeat;
    int          n_init;
    int          n_check;
    int          n_ignored;
    logic [31:0] now_ms;
    int          used_cl;
    int          used_rk;
    int          step_span;

    multi_channel_heartbeat_watchdog uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    multi_channel_heartbeat_watchdog_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left),
        .fault_count    (fault_count),
        .recover_count  (recover_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(input logic [1:0]  act,
                             input logic [1:0]  cl,
                             input logic [3:0]  rk,
                             input logic [31:0] t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, t, rk, cl};
        s_tuser  <= act;
        case (act)
            hbwd_pkg::ACT_HEARTBEAT: n_heartbeat++;
            hbwd_pkg::ACT_INIT:      n_init++;
            hbwd_pkg::ACT_CHECK:     n_check++;
            default:                 n_ignored++;
        endcase
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] timeout_val;
        logic [2:0]  cl_val;
        logic [4:0]  rk_val;
        logic [1:0]  cl;
        logic [3:0]  rk;
        int          count;
        int          n;
        int          pick;
        int          roll;

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        n_heartbeat    = 0;
        n_init         = 0;
        n_check        = 0;
        n_ignored      = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: timeout 1000, full 4 x 16 table
        send_word(hbwd_pkg::ACT_CHECK,     2'd0, 4'd0,  32'd0);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd0, 4'd0,  32'd0);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd0, 4'd0,  32'd100);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd3, 4'd15, 32'd200);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd2, 4'd7,  32'hFFFF_FFF0);
        send_word(ACT_UNUSED,              2'd1, 4'd1,  32'd5);
        // age wraps past zero for the last heartbeat
        send_word(hbwd_pkg::ACT_CHECK,     2'd0, 4'd0,  32'h0000_0010);
        send_word(hbwd_pkg::ACT_INIT,      2'd0, 4'd0,  32'h0000_0020);
        // age equal to the timeout is not stale, one more is
        send_word(hbwd_pkg::ACT_CHECK,     2'd1, 4'd3,  32'h0000_0020 + 32'd1000);
        send_word(hbwd_pkg::ACT_CHECK,     2'd2, 4'd9,  32'h0000_0020 + 32'd1001);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd3, 4'd15, 32'hFFFF_FFFF);
        send_word(hbwd_pkg::ACT_CHECK,     2'd3, 4'd15, 32'hFFFF_FFFF);
        send_word(hbwd_pkg::ACT_HEARTBEAT, 2'd1, 4'd10, 32'd12345);
        send_word(hbwd_pkg::ACT_CHECK,     2'd0, 4'd0,  32'd12345);
        send_word(hbwd_pkg::ACT_CHECK,     2'd0, 4'd0,  32'd12345);
        send_word(hbwd_pkg::ACT_INIT,      2'd3, 4'd15, 32'd0);
        send_word(hbwd_pkg::ACT_CHECK,     2'd0, 4'd0,  32'd0);

        for (int i = 0; i < NUM_SETTINGS; i++)
        begin
            drain();
            case (i)
                0:       begin timeout_val = 32'd50;          cl_val = 3'd7; rk_val = 5'd31; end
                1:       begin timeout_val = 32'd0;           cl_val = 3'd2; rk_val = 5'd5;  end
                2:       begin timeout_val = 32'hFFFF_FFFF;   cl_val = 3'd4; rk_val = 5'd16; end
                3:       begin timeout_val = $urandom_range(100, 3000);
                               cl_val = 3'd3; rk_val = 5'd0; end
                4:       begin timeout_val = 32'd500;         cl_val = 3'd0; rk_val = 5'd9;  end
                default: begin timeout_val = $urandom_range(1, 4000);
                               cl_val = 3'($urandom_range(0, 7));
                               rk_val = 5'($urandom_range(0, 31)); end
            endcase
            write_reg(hbwd_pkg::REG_TIMEOUT,  timeout_val);
            write_reg(hbwd_pkg::REG_CLUSTERS, {29'd0, cl_val});
            write_reg(hbwd_pkg::REG_RACKS,    {27'd0, rk_val});
            cfg_we <= 1'b0;

            case (i % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase

            used_cl   = (cl_val > hbwd_pkg::MAX_CLUSTER_SLOTS)
                      ? hbwd_pkg::MAX_CLUSTER_SLOTS : int'(cl_val);
            used_rk   = (rk_val > hbwd_pkg::MAX_RACK_SLOTS)
                      ? hbwd_pkg::MAX_RACK_SLOTS : int'(rk_val);
            step_span = (timeout_val == 0) ? 2 :
                        (timeout_val > 32'd20000) ? 20000 : int'(timeout_val / 3) + 1;
            count     = (i == 3 || i == 4) ? 10 : 35;
            now_ms    = $urandom;

            n = 0;
            while (n < count)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    now_ms = $urandom;
                else if (roll >= 40)
                    now_ms = now_ms + $urandom_range(1, step_span);

                if ($urandom_range(9) < 7 && used_cl > 0 && used_rk > 0)
                begin
                    cl = 2'($urandom_range(used_cl - 1));
                    rk = 4'($urandom_range(used_rk - 1));
                end
                else
                begin
                    cl = 2'($urandom_range(3));
                    rk = 4'($urandom_range(15));
                end

                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    send_word(hbwd_pkg::ACT_HEARTBEAT, cl, rk, now_ms);
                    n++;
                end
                else if (pick < 52)
                begin
                    send_word(hbwd_pkg::ACT_INIT, 2'($urandom_range(3)),
                              4'($urandom_range(15)), now_ms);
                    n++;
                end
                else if (pick < 92)
                begin
                    send_word(hbwd_pkg::ACT_CHECK, 2'($urandom_range(3)),
                              4'($urandom_range(15)), now_ms);
                    n++;
                end
                else if (pick < 96)
                    send_word(ACT_UNUSED, cl, rk, $urandom);
                else
                begin
                    send_word(hbwd_pkg::ACT_HEARTBEAT, cl, rk, $urandom);
                    n++;
                end
            end
        end

        drain();

        $display("Sent %0d heartbeats, %0d inits, %0d check ticks, %0d unused words",
                 n_heartbeat, n_init, n_check, n_ignored);
        $display("over %0d settings; checked %0d fault and %0d recovery words, %0d mismatches",
                 NUM_SETTINGS + 1, fault_count, recover_count, mismatch_count);
        if (mismatch_count == 0 && expected_left == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
